[rtl/asd_pkg.sv]
package asd_pkg;

	// fixed field widths
	localparam int FREQ_BITS    = 16;
	localparam int WINDOW_BITS  = 32;
	localparam int OP_BITS      = 2;
	localparam int INDEX_BITS   = 8;
	localparam int STATUS_BITS  = 2;
	localparam int SYMBOL_BITS  = 8;
	localparam int USED_BITS    = 6;
	localparam int SCOUNT_BITS  = 9;
	// wide enough for symbol counts, table indexes and MAX_SYMBOLS up to 4096
	localparam int CNT_BITS     = 13;

	// parameter defaults
	localparam int CODE_BITS_DEF   = 32;
	localparam int MAX_SYMBOLS_DEF = 256;

	localparam logic [SCOUNT_BITS-1:0] SCOUNT_RESET = 9'd256;

	// item operations
	localparam logic [OP_BITS-1:0] OP_LOAD   = 2'd0;
	localparam logic [OP_BITS-1:0] OP_START  = 2'd1;
	localparam logic [OP_BITS-1:0] OP_DECODE = 2'd2;

	// result status codes
	localparam logic [STATUS_BITS-1:0] ST_DECODED = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_WRITTEN = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_STARTED = 2'd2;
	localparam logic [STATUS_BITS-1:0] ST_ERROR   = 2'd3;

	// request to the serial multiply/divide unit
	typedef struct packed {
		logic start;
		logic dec;
	} md_req_t;

endpackage

[rtl/asd_cum_table.sv]
module asd_cum_table #(
	parameter int DEPTH = asd_pkg::MAX_SYMBOLS_DEF,
	parameter int AW    = $clog2(asd_pkg::MAX_SYMBOLS_DEF)
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [asd_pkg::FREQ_BITS-1:0] wr_data,
	input  logic [AW-1:0]                 rd_addr,
	output logic [asd_pkg::FREQ_BITS-1:0] rd_data
);

	logic [asd_pkg::FREQ_BITS-1:0] mem_q [DEPTH];
	logic [asd_pkg::FREQ_BITS-1:0] rd_data_q;

	// single write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/asd_muldiv.sv]
// serial (a * b - dec) / d: one multiplier bit per cycle, then one quotient bit per cycle
module asd_muldiv #(
	parameter int CODE_BITS = asd_pkg::CODE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  asd_pkg::md_req_t              req,
	input  logic [CODE_BITS:0]            a,
	input  logic [asd_pkg::FREQ_BITS-1:0] b,
	input  logic [CODE_BITS:0]            d,
	output logic                          done,
	output logic [CODE_BITS+asd_pkg::FREQ_BITS:0] q
);

	localparam int FB = asd_pkg::FREQ_BITS;
	localparam int PW = CODE_BITS + 1 + FB;
	localparam int RW = CODE_BITS + 1;
	localparam int CW = $clog2(PW + 1);

	typedef enum logic [2:0] {
		MD_IDLE = 3'b001,
		MD_MUL  = 3'b010,
		MD_DIV  = 3'b100
	} md_state_t;

	md_state_t         state_q;
	logic [PW-1:0]     acc_q;
	logic [RW-1:0]     a_q;
	logic [RW-1:0]     d_q;
	logic [FB-1:0]     b_q;
	logic [RW-1:0]     rem_q;
	logic [CW-1:0]     cnt_q;
	logic              dec_q;
	logic              done_q;

	logic [PW-1:0]     mul_next;
	logic [RW-1:0]     rem_shift;
	logic [RW:0]       rem_diff;
	logic              ge;

	// multiply step, msb of b first
	always_comb begin
		mul_next = {acc_q[PW-2:0], 1'b0} + (b_q[FB-1] ? PW'(a_q) : '0);
	end

	// restoring divide step: remainder stays below d, so the shift fits RW bits while d is below 2**CODE_BITS
	always_comb begin
		rem_shift = {rem_q[RW-2:0], acc_q[PW-1]};
		rem_diff  = {1'b0, rem_shift} - {1'b0, d_q};
		ge        = ~rem_diff[RW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				MD_IDLE: begin
					if (req.start) begin
						state_q <= MD_MUL;
						cnt_q   <= CW'(FB);
					end
				end
				MD_MUL: begin
					if (cnt_q == CW'(1)) begin
						state_q <= MD_DIV;
						cnt_q   <= CW'(PW);
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				MD_DIV: begin
					if (cnt_q == CW'(1)) begin
						state_q <= MD_IDLE;
						done_q  <= 1'b1;
					end
					cnt_q <= cnt_q - CW'(1);
				end
				default: begin
					state_q <= MD_IDLE;
				end
			endcase
		end
	end

	// datapath: acc holds the product, then shifts out dividend bits and in quotient bits
	always_ff @(posedge clk) begin
		case (state_q)
			MD_IDLE: begin
				if (req.start) begin
					a_q   <= a;
					b_q   <= b;
					d_q   <= d;
					dec_q <= req.dec;
					acc_q <= '0;
				end
			end
			MD_MUL: begin
				b_q <= {b_q[FB-2:0], 1'b0};
				if (cnt_q == CW'(1)) begin
					acc_q <= mul_next - PW'(dec_q);
					rem_q <= '0;
				end else begin
					acc_q <= mul_next;
				end
			end
			MD_DIV: begin
				rem_q <= ge ? rem_diff[RW-1:0] : rem_shift;
				acc_q <= {acc_q[PW-2:0], ge};
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign q    = acc_q;

endmodule

[rtl/arithmetic_symbol_decoder_core.sv]
// Integer arithmetic decoder with a static cumulative-frequency table. A load beat
// writes one table entry if its index is in range, a start beat resets the interval
// and takes CODE_BITS code bits, a decode beat returns one symbol and the number of
// code bits it consumed. A decode beat runs target scaling and the two interval
// bounds in the shared serial multiply/divide unit, searches table entries through
// the single registered table read port, and makes at most CODE_BITS renormalization
// shifts.
// A new beat is taken while the previous result still waits on the output.
// symbol_count may be written whenever the block is idle; cfg_ready is always high.
module arithmetic_symbol_decoder_core #(
	parameter int CODE_BITS   = asd_pkg::CODE_BITS_DEF,
	parameter int MAX_SYMBOLS = asd_pkg::MAX_SYMBOLS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [asd_pkg::SCOUNT_BITS-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [asd_pkg::OP_BITS-1:0]     op,
	input  logic [asd_pkg::INDEX_BITS-1:0]  entry_index,
	input  logic [asd_pkg::FREQ_BITS-1:0]   entry_cum_freq,
	input  logic [asd_pkg::WINDOW_BITS-1:0] code_window,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [asd_pkg::STATUS_BITS-1:0] status,
	output logic [asd_pkg::SYMBOL_BITS-1:0] symbol,
	output logic [asd_pkg::USED_BITS-1:0]   bits_used
);

	localparam int CW  = CODE_BITS;
	localparam int FB  = asd_pkg::FREQ_BITS;
	localparam int WB  = asd_pkg::WINDOW_BITS;
	localparam int NB  = asd_pkg::CNT_BITS;
	localparam int AW  = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
	localparam int PW  = CW + 1 + FB;
	localparam int KW  = $clog2(CW + 1);
	localparam logic [CW-1:0] HALF    = {1'b1, {(CW-1){1'b0}}};
	localparam logic [CW-1:0] QUARTER = {2'b01, {(CW-2){1'b0}}};
	localparam logic [CW-1:0] THREEQ  = {2'b11, {(CW-2){1'b0}}};

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_SC_RD  = 10'b0000000010,
		S_SC_GET = 10'b0000000100,
		S_T_RUN  = 10'b0000001000,
		S_SR_RD  = 10'b0000010000,
		S_SR_CMP = 10'b0000100000,
		S_H_RUN  = 10'b0001000000,
		S_L_RUN  = 10'b0010000000,
		S_RENORM = 10'b0100000000,
		S_FIN    = 10'b1000000000
	} state_t;

	state_t                          state_q;
	logic [asd_pkg::SCOUNT_BITS-1:0] scount_q;
	logic [CW-1:0]                   low_q;
	logic [CW-1:0]                   high_q;
	logic [CW-1:0]                   code_q;
	logic [WB-1:0]                   window_q;
	logic [FB-1:0]                   scale_q;
	logic [CW:0]                     range_q;
	logic [FB-1:0]                   tgt_q;
	logic                            tovf_q;
	logic [AW-1:0]                   addr_q;
	logic [AW-1:0]                   idx_q;
	logic [FB-1:0]                   prev_q;
	logic [FB-1:0]                   first_q;
	logic [FB-1:0]                   hicf_q;
	logic [FB-1:0]                   locf_q;
	logic [AW-1:0]                   sym_q;
	logic [CW-1:0]                   hq_q;
	logic [KW-1:0]                   k_q;
	logic                            md_start_q;
	logic [asd_pkg::STATUS_BITS-1:0] res_status_q;
	logic [asd_pkg::SYMBOL_BITS-1:0] res_sym_q;
	logic [asd_pkg::USED_BITS-1:0]   res_used_q;
	logic                            out_valid_q;
	logic [asd_pkg::STATUS_BITS-1:0] status_q;
	logic [asd_pkg::SYMBOL_BITS-1:0] symbol_q;
	logic [asd_pkg::USED_BITS-1:0]   bits_used_q;

	logic                            in_fire;
	logic                            idx_ok;
	logic [NB-1:0]                   cnt_act;
	logic [AW-1:0]                   last_idx;
	logic [FB-1:0]                   rd_data;
	logic [CW:0]                     diff_ext;
	logic [CW:0]                     range_c;
	logic                            hit;
	logic                            md_done;
	logic [PW-1:0]                   md_q;
	asd_pkg::md_req_t                md_req;
	logic [CW:0]                     md_a;
	logic [FB-1:0]                   md_b;
	logic [CW:0]                     md_d;
	logic [CW-1:0]                   rn_off;
	logic                            rn_go;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid & in_ready;
	assign cfg_ready = 1'b1;

	// active symbol count, clamped to 1..MAX_SYMBOLS
	always_comb begin
		cnt_act = NB'(scount_q);
		if (cnt_act == '0) begin
			cnt_act = NB'(1);
		end
		if (cnt_act > NB'(MAX_SYMBOLS)) begin
			cnt_act = NB'(MAX_SYMBOLS);
		end
		last_idx = AW'(cnt_act - NB'(1));
	end

	assign idx_ok = NB'(entry_index) < NB'(MAX_SYMBOLS);

	// interval arithmetic at CODE_BITS bits
	assign diff_ext = {1'b0, code_q - low_q} + (CW+1)'(1);
	assign range_c  = {1'b0, high_q - low_q} + (CW+1)'(1);

	// search compare: lower <= target < upper
	assign hit = ~tovf_q && (prev_q <= tgt_q) && (tgt_q < rd_data);

	asd_cum_table #(
		.DEPTH(MAX_SYMBOLS),
		.AW   (AW)
	) u_table (
		.clk    (clk),
		.wr_en  (in_fire && (op == asd_pkg::OP_LOAD) && idx_ok),
		.wr_addr(AW'(entry_index)),
		.wr_data(entry_cum_freq),
		.rd_addr(addr_q),
		.rd_data(rd_data)
	);

	// operand select for the shared multiply/divide unit
	always_comb begin
		md_req.start = md_start_q;
		md_req.dec   = (state_q == S_T_RUN);
		md_a = range_q;
		md_b = hicf_q;
		md_d = (CW+1)'(scale_q);
		case (state_q)
			S_T_RUN: begin
				md_a = diff_ext;
				md_b = scale_q;
				md_d = range_q;
			end
			S_L_RUN: begin
				md_b = locf_q;
			end
			default: begin
			end
		endcase
	end

	asd_muldiv #(
		.CODE_BITS(CODE_BITS)
	) u_muldiv (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (md_req),
		.a     (md_a),
		.b     (md_b),
		.d     (md_d),
		.done  (md_done),
		.q     (md_q)
	);

	// renormalization step select
	always_comb begin
		rn_go  = 1'b1;
		rn_off = '0;
		if (high_q < HALF) begin
			rn_off = '0;
		end else if (low_q >= HALF) begin
			rn_off = HALF;
		end else if ((low_q >= QUARTER) && (high_q <= THREEQ)) begin
			rn_off = QUARTER;
		end else begin
			rn_go = 1'b0;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scount_q    <= asd_pkg::SCOUNT_RESET;
			low_q       <= '0;
			high_q      <= '1;
			code_q      <= '0;
			md_start_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			md_start_q <= 1'b0;
			if (cfg_valid) begin
				scount_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						case (op)
							asd_pkg::OP_LOAD: begin
								state_q <= S_FIN;
							end
							asd_pkg::OP_START: begin
								low_q   <= '0;
								high_q  <= '1;
								code_q  <= code_window[WB-1 -: CW];
								state_q <= S_FIN;
							end
							asd_pkg::OP_DECODE: begin
								state_q <= S_SC_RD;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_SC_RD: begin
					state_q <= S_SC_GET;
				end
				S_SC_GET: begin
					if (rd_data == '0) begin
						state_q <= S_FIN;
					end else begin
						md_start_q <= 1'b1;
						state_q    <= S_T_RUN;
					end
				end
				S_T_RUN: begin
					if (md_done) begin
						state_q <= S_SR_RD;
					end
				end
				S_SR_RD: begin
					state_q <= S_SR_CMP;
				end
				S_SR_CMP: begin
					if (hit || (idx_q == last_idx)) begin
						md_start_q <= 1'b1;
						state_q    <= S_H_RUN;
					end else begin
						state_q <= S_SR_RD;
					end
				end
				S_H_RUN: begin
					if (md_done) begin
						md_start_q <= 1'b1;
						state_q    <= S_L_RUN;
					end
				end
				S_L_RUN: begin
					if (md_done) begin
						high_q  <= low_q + hq_q - CW'(1);
						low_q   <= low_q + md_q[CW-1:0];
						state_q <= S_RENORM;
					end
				end
				S_RENORM: begin
					if ((k_q == KW'(CW)) || !rn_go) begin
						state_q <= S_FIN;
					end else begin
						low_q  <= (low_q - rn_off) << 1;
						high_q <= ((high_q - rn_off) << 1) | CW'(1);
						code_q <= ((code_q - rn_off) << 1) | CW'(window_q[WB-1]);
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				window_q  <= code_window;
				addr_q    <= last_idx;
				k_q       <= '0;
				res_sym_q <= '0;
				case (op)
					asd_pkg::OP_LOAD: begin
						res_status_q <= idx_ok ? asd_pkg::ST_WRITTEN : asd_pkg::ST_ERROR;
						res_used_q   <= '0;
					end
					asd_pkg::OP_START: begin
						res_status_q <= asd_pkg::ST_STARTED;
						res_used_q   <= asd_pkg::USED_BITS'(CW);
					end
					asd_pkg::OP_DECODE: begin
						res_status_q <= asd_pkg::ST_DECODED;
						res_used_q   <= '0;
					end
					default: begin
						res_status_q <= asd_pkg::ST_ERROR;
						res_used_q   <= '0;
					end
				endcase
			end
			S_SC_GET: begin
				scale_q <= rd_data;
				range_q <= range_c;
			end
			S_T_RUN: begin
				tgt_q  <= md_q[FB-1:0];
				tovf_q <= |md_q[PW-1:FB];
				addr_q <= '0;
				idx_q  <= '0;
				prev_q <= '0;
			end
			S_SR_CMP: begin
				if (idx_q == '0) begin
					first_q <= rd_data;
				end
				if (hit) begin
					sym_q  <= idx_q;
					hicf_q <= rd_data;
					locf_q <= prev_q;
				end else if (idx_q == last_idx) begin
					sym_q  <= '0;
					hicf_q <= (idx_q == '0) ? rd_data : first_q;
					locf_q <= '0;
				end else begin
					idx_q  <= idx_q + AW'(1);
					addr_q <= idx_q + AW'(1);
					prev_q <= rd_data;
				end
			end
			S_H_RUN: begin
				hq_q      <= md_q[CW-1:0];
				res_sym_q <= asd_pkg::SYMBOL_BITS'(sym_q);
			end
			S_RENORM: begin
				if ((k_q != KW'(CW)) && rn_go) begin
					k_q      <= k_q + KW'(1);
					window_q <= {window_q[WB-2:0], 1'b0};
				end else begin
					res_used_q <= asd_pkg::USED_BITS'(k_q);
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					status_q    <= res_status_q;
					symbol_q    <= res_sym_q;
					bits_used_q <= res_used_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign symbol    = symbol_q;
	assign bits_used = bits_used_q;

endmodule
